// ===== rtl/wmcs_pkg.sv =====
package wmcs_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = 3;
    localparam int WREG_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int SAMPLE_W  = 32;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_LSB   = 2;

    typedef logic [NUM_SLOTS-1:0][WREG_W-1:0]   weight_arr_t;
    typedef logic [NUM_SLOTS-1:0][SAMPLE_W-1:0] sample_arr_t;

    function automatic int used_weight_bits(int wb);
        return (wb < WREG_W) ? wb : WREG_W;
    endfunction

    function automatic int used_frac_bits(int fb);
        return (fb < FRAC_W) ? fb : FRAC_W;
    endfunction

    // running sums of n weights never overflow this width
    function automatic int sum_width(int n, int wb);
        return used_weight_bits(wb) + $clog2(n);
    endfunction

endpackage

// ===== rtl/wmcs_regs.sv =====
module wmcs_regs
    import wmcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output weight_arr_t       weights
);

    weight_arr_t                       weight_reg;
    logic        [ADDR_W-REG_LSB-1:0] reg_index;

    assign reg_index = paddr[ADDR_W-1:REG_LSB];
    assign pready    = 1'b1;
    assign weights   = weight_reg;
    assign prdata    = {{(DATA_W-WREG_W){1'b0}}, weight_reg[reg_index]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                weight_reg[k] <= WREG_W'(1);
            end
        end else if (psel && penable && pwrite) begin
            weight_reg[reg_index] <= pwdata[WREG_W-1:0];
        end
    end

endmodule

// ===== rtl/wmcs_scale.sv =====
module wmcs_scale
    import wmcs_pkg::*;
#(
    parameter int NUM_COMPONENTS = 8,
    parameter int WEIGHT_BITS    = 16,
    parameter int FRACTION_BITS  = 16,
    localparam int SUM_W = sum_width(NUM_COMPONENTS, WEIGHT_BITS)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  weight_arr_t                         weights,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [FRAC_W-1:0]                   in_fraction,
    input  sample_arr_t                         in_samples,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sample_arr_t                         out_samples,
    output logic [NUM_COMPONENTS-1:0][SUM_W-1:0] out_cum,
    output logic [SUM_W-1:0]                    out_scaled,
    output logic                                out_zero
);

    localparam int WU     = used_weight_bits(WEIGHT_BITS);
    localparam int FU     = used_frac_bits(FRACTION_BITS);
    localparam int PROD_W = FU + SUM_W;

    logic [SUM_W-1:0]                     run_sum;
    logic [NUM_COMPONENTS-1:0][SUM_W-1:0] cum1_next;
    logic [PROD_W-1:0]                    product;
    logic                                 en1;
    logic                                 en2;

    // prefix stage
    logic                                 v1_reg;
    logic [FU-1:0]                        frac1_reg;
    sample_arr_t                          samp1_reg;
    logic [NUM_COMPONENTS-1:0][SUM_W-1:0] cum1_reg;

    // scale stage
    logic                                 v2_reg;
    sample_arr_t                          samp2_reg;
    logic [NUM_COMPONENTS-1:0][SUM_W-1:0] cum2_reg;
    logic [SUM_W-1:0]                     scaled2_reg;
    logic                                 zero2_reg;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        run_sum = '0;
        for (int k = 0; k < NUM_COMPONENTS; k++) begin
            run_sum      = run_sum + SUM_W'(weights[k][WU-1:0]);
            cum1_next[k] = run_sum;
        end
    end

    assign product = PROD_W'(frac1_reg) * PROD_W'(cum1_reg[NUM_COMPONENTS-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            frac1_reg <= in_fraction[FU-1:0];
            samp1_reg <= in_samples;
            cum1_reg  <= cum1_next;
        end
        if (en2 && v1_reg) begin
            samp2_reg   <= samp1_reg;
            cum2_reg    <= cum1_reg;
            scaled2_reg <= SUM_W'(product >> FRACTION_BITS);
            zero2_reg   <= (cum1_reg[NUM_COMPONENTS-1] == '0);
        end
    end

    assign out_valid   = v2_reg;
    assign out_samples = samp2_reg;
    assign out_cum     = cum2_reg;
    assign out_scaled  = scaled2_reg;
    assign out_zero    = zero2_reg;

endmodule

// ===== rtl/wmcs_pick.sv =====
module wmcs_pick
    import wmcs_pkg::*;
#(
    parameter int NUM_COMPONENTS = 8,
    parameter int WEIGHT_BITS    = 16,
    localparam int SUM_W = sum_width(NUM_COMPONENTS, WEIGHT_BITS)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sample_arr_t                         in_samples,
    input  logic [NUM_COMPONENTS-1:0][SUM_W-1:0] in_cum,
    input  logic [SUM_W-1:0]                    in_scaled,
    input  logic                                in_zero,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [IDX_W-1:0]                    m_chosen_index,
    output logic [SAMPLE_W-1:0]                 m_chosen_sample,
    output logic                                m_all_weights_zero
);

    logic [IDX_W-1:0] idx3_next;
    logic             en3;
    logic             en4;

    logic             v3_reg;
    logic [IDX_W-1:0] idx3_reg;
    logic             zero3_reg;
    sample_arr_t      samp3_reg;

    logic                m_valid_reg;
    logic [IDX_W-1:0]    m_index_reg;
    logic [SAMPLE_W-1:0] m_sample_reg;
    logic                m_zero_reg;

    assign en4      = !m_valid_reg || m_ready;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    // first component whose running sum exceeds the scaled fraction
    always_comb begin
        idx3_next = IDX_W'(NUM_COMPONENTS - 1);
        for (int k = NUM_COMPONENTS - 1; k >= 0; k--) begin
            if (in_cum[k] > in_scaled) begin
                idx3_next = IDX_W'(k);
            end
        end
        if (in_zero) begin
            idx3_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en3) begin
                v3_reg <= in_valid;
            end
            if (en4) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && in_valid) begin
            idx3_reg  <= idx3_next;
            zero3_reg <= in_zero;
            samp3_reg <= in_samples;
        end
        if (en4 && v3_reg) begin
            m_index_reg  <= idx3_reg;
            m_sample_reg <= samp3_reg[idx3_reg];
            m_zero_reg   <= zero3_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_chosen_index     = m_index_reg;
    assign m_chosen_sample    = m_sample_reg;
    assign m_all_weights_zero = m_zero_reg;

`ifndef SYNTHESIS
    a_scaled_below_total: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && !in_zero |-> in_scaled < in_cum[NUM_COMPONENTS-1])
        else $error("scaled fraction not below total weight");

    a_zero_picks_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_all_weights_zero |-> m_chosen_index == '0)
        else $error("all-zero weights must pick component zero");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {1'b0, m_chosen_index} < (IDX_W + 1)'(NUM_COMPONENTS))
        else $error("chosen index beyond component count");

    a_beat_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> v3_reg)
        else $error("accepted beat lost in select stage");
`endif

endmodule

// ===== rtl/weighted_mixture_component_select.sv =====
// weighted mixture component select: one inverse-cdf draw per beat
// input channel (s_valid/s_ready): a 0.16 uniform fraction and one 32-bit
// sample word per component. result channel (m_valid/m_ready): the index of
// the first component whose running weight sum exceeds fraction * total,
// that component's sample word, and a flag set when every weight is zero
// (index 0 is then returned). otherwise zero-weight components are never chosen.
// weights are written over the apb port at byte address 4*i, 16 bits each,
// and the user must change them only while no beat is in flight; the block does not enforce this.
// pipeline: input handshake to m_valid passes through the prefix
// sum, scale multiply, compare/priority and output mux stages.
// throughput: one beat per cycle while m_ready stays high, with a single 16 x 19 multiplier stage.
// stall: each stage holds its beat while the one after it is full and stalled, so up to
// four beats wait inside; s_ready drops only when all stages are full.
// reset: synchronous, active low; every weight returns to 1, pipeline empties.
module weighted_mixture_component_select
    import wmcs_pkg::*;
#(
    parameter int NUM_COMPONENTS = 8,
    parameter int WEIGHT_BITS    = 16,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FRAC_W-1:0]   s_random_fraction,
    input  logic [SAMPLE_W-1:0] s_sample_zero,
    input  logic [SAMPLE_W-1:0] s_sample_one,
    input  logic [SAMPLE_W-1:0] s_sample_two,
    input  logic [SAMPLE_W-1:0] s_sample_three,
    input  logic [SAMPLE_W-1:0] s_sample_four,
    input  logic [SAMPLE_W-1:0] s_sample_five,
    input  logic [SAMPLE_W-1:0] s_sample_six,
    input  logic [SAMPLE_W-1:0] s_sample_seven,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [IDX_W-1:0]    m_chosen_index,
    output logic [SAMPLE_W-1:0] m_chosen_sample,
    output logic                m_all_weights_zero
);

    localparam int SUM_W = sum_width(NUM_COMPONENTS, WEIGHT_BITS);

    weight_arr_t                          weights;
    sample_arr_t                          in_samples;
    logic                                 mid_valid;
    logic                                 mid_ready;
    sample_arr_t                          mid_samples;
    logic [NUM_COMPONENTS-1:0][SUM_W-1:0] mid_cum;
    logic [SUM_W-1:0]                     mid_scaled;
    logic                                 mid_zero;

    assign in_samples = {s_sample_seven, s_sample_six, s_sample_five, s_sample_four,
                         s_sample_three, s_sample_two, s_sample_one, s_sample_zero};

    wmcs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .weights (weights)
    );

    wmcs_scale #(
        .NUM_COMPONENTS (NUM_COMPONENTS),
        .WEIGHT_BITS    (WEIGHT_BITS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .weights     (weights),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_fraction (s_random_fraction),
        .in_samples  (in_samples),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .out_samples (mid_samples),
        .out_cum     (mid_cum),
        .out_scaled  (mid_scaled),
        .out_zero    (mid_zero)
    );

    wmcs_pick #(
        .NUM_COMPONENTS (NUM_COMPONENTS),
        .WEIGHT_BITS    (WEIGHT_BITS)
    ) u_pick (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (mid_valid),
        .in_ready           (mid_ready),
        .in_samples         (mid_samples),
        .in_cum             (mid_cum),
        .in_scaled          (mid_scaled),
        .in_zero            (mid_zero),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chosen_index     (m_chosen_index),
        .m_chosen_sample    (m_chosen_sample),
        .m_all_weights_zero (m_all_weights_zero)
    );

endmodule

// ===== test/tb_weighted_mixture_component_select.sv =====
`timescale 1ns / 1ps

module tb_weighted_mixture_component_select;
    import wmcs_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTINGS_RANDOM = 24;
    localparam int DRAWS_PER_SETTING = 52;

    typedef struct {
        logic [FRAC_W-1:0] fraction;
        sample_arr_t       samples;
    } draw_req_t;

    typedef struct {
        logic [IDX_W-1:0]    index;
        logic [SAMPLE_W-1:0] sample;
        logic                all_zero;
    } draw_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [FRAC_W-1:0]   s_random_fraction = '0;
    logic [SAMPLE_W-1:0] s_sample_zero = '0;
    logic [SAMPLE_W-1:0] s_sample_one = '0;
    logic [SAMPLE_W-1:0] s_sample_two = '0;
    logic [SAMPLE_W-1:0] s_sample_three = '0;
    logic [SAMPLE_W-1:0] s_sample_four = '0;
    logic [SAMPLE_W-1:0] s_sample_five = '0;
    logic [SAMPLE_W-1:0] s_sample_six = '0;
    logic [SAMPLE_W-1:0] s_sample_seven = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [IDX_W-1:0]    m_chosen_index;
    logic [SAMPLE_W-1:0] m_chosen_sample;
    logic                m_all_weights_zero;

    weight_arr_t weight_shadow = {NUM_SLOTS{WREG_W'(1)}};
    draw_req_t   pending_draws[$];
    draw_res_t   expected_draws[$];
    draw_req_t   draw_on_bus;
    draw_res_t   draw_got;
    draw_res_t   draw_want;

    int send_idle_pct = 35;
    int recv_idle_pct = 83;
    int error_count = 0;
    int draws_accepted = 0;
    int draws_checked = 0;
    int zero_total_draws = 0;
    int settings_applied = 0;
    int stall_cycles = 0;

    weighted_mixture_component_select i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_random_fraction  (s_random_fraction),
        .s_sample_zero      (s_sample_zero),
        .s_sample_one       (s_sample_one),
        .s_sample_two       (s_sample_two),
        .s_sample_three     (s_sample_three),
        .s_sample_four      (s_sample_four),
        .s_sample_five      (s_sample_five),
        .s_sample_six       (s_sample_six),
        .s_sample_seven     (s_sample_seven),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chosen_index     (m_chosen_index),
        .m_chosen_sample    (m_chosen_sample),
        .m_all_weights_zero (m_all_weights_zero)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // inverse-cdf pick over the current weights
    function automatic draw_res_t select_component(input draw_req_t req);
        longint unsigned running [NUM_SLOTS];
        longint unsigned total_w;
        longint unsigned scaled;
        draw_res_t res;
        bit found;
        total_w = 0;
        found = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            total_w += weight_shadow[k];
            running[k] = total_w;
        end
        res.all_zero = (total_w == 0);
        res.index = IDX_W'(NUM_SLOTS - 1);
        if (total_w == 0) begin
            res.index = '0;
        end else begin
            scaled = (longint'(req.fraction) * total_w) >> FRAC_W;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (!found && running[k] > scaled) begin
                    res.index = IDX_W'(k);
                    found = 1'b1;
                end
            end
        end
        res.sample = req.samples[res.index];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic queue_draw(input logic [FRAC_W-1:0] fraction);
        draw_req_t req;
        req.fraction = fraction;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            req.samples[k] = $urandom;
        end
        pending_draws = {pending_draws, req};
    endtask

    task automatic write_weights(input weight_arr_t plan);
        for (int k = 0; k < NUM_SLOTS; k++) begin
            @(posedge aclk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= ADDR_W'(k << REG_LSB);
            pwdata <= {(DATA_W-WREG_W)'($urandom), plan[k]};
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            weight_shadow[k] = plan[k];
        end
        settings_applied++;
    endtask

    task automatic wait_drain();
        do begin
            @(negedge aclk);
        end while (pending_draws.size() != 0 || s_valid || expected_draws.size() != 0);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_draws = {expected_draws, select_component(draw_on_bus)};
                draws_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_draws.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    draw_on_bus = pending_draws.pop_front();
                    s_valid <= 1'b1;
                    s_random_fraction <= draw_on_bus.fraction;
                    s_sample_zero <= draw_on_bus.samples[0];
                    s_sample_one <= draw_on_bus.samples[1];
                    s_sample_two <= draw_on_bus.samples[2];
                    s_sample_three <= draw_on_bus.samples[3];
                    s_sample_four <= draw_on_bus.samples[4];
                    s_sample_five <= draw_on_bus.samples[5];
                    s_sample_six <= draw_on_bus.samples[6];
                    s_sample_seven <= draw_on_bus.samples[7];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                draw_got.index = m_chosen_index;
                draw_got.sample = m_chosen_sample;
                draw_got.all_zero = m_all_weights_zero;
                if (expected_draws.size() == 0) begin
                    report_mismatch("result beat with no draw outstanding");
                end else begin
                    draw_want = expected_draws.pop_front();
                    if (draw_got.index !== draw_want.index)
                        report_mismatch($sformatf("draw %0d chosen_index %0d, expected %0d",
                            draws_checked, draw_got.index, draw_want.index));
                    if (draw_got.sample !== draw_want.sample)
                        report_mismatch($sformatf("draw %0d chosen_sample %h, expected %h",
                            draws_checked, draw_got.sample, draw_want.sample));
                    if (draw_got.all_zero !== draw_want.all_zero)
                        report_mismatch($sformatf("draw %0d all_weights_zero %b, expected %b",
                            draws_checked, draw_got.all_zero, draw_want.all_zero));
                    if (draw_want.all_zero)
                        zero_total_draws++;
                    draws_checked++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        weight_arr_t plan;
        longint total_w;
        longint cum_w;
        longint frac;
        int pick;
        int shape;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset weights: all ones, boundaries at multiples of 1/8
        queue_draw('0);
        queue_draw('1);
        for (int k = 1; k < NUM_SLOTS; k++) begin
            queue_draw(FRAC_W'(k * 16'h2000 - 1));
            queue_draw(FRAC_W'(k * 16'h2000));
        end
        wait_drain();

        // all weights zero
        write_weights('0);
        queue_draw('0);
        queue_draw('1);
        wait_drain();

        // all weights at max
        write_weights('1);
        queue_draw('0);
        queue_draw('1);
        wait_drain();

        // only the last component carries weight
        plan = '0;
        plan[NUM_SLOTS-1] = WREG_W'(1);
        write_weights(plan);
        queue_draw('0);
        queue_draw('1);
        wait_drain();

        for (int s = 0; s < SETTINGS_RANDOM; s++) begin
            if (s < SETTINGS_RANDOM / 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 83;
            end else if (s < 2 * SETTINGS_RANDOM / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            shape = $urandom_range(0, 6);
            for (int k = 0; k < NUM_SLOTS; k++) begin
                case (shape)
                    0: begin
                        plan[k] = WREG_W'($urandom);
                    end
                    1: begin
                        plan[k] = WREG_W'($urandom_range(0, 3));
                    end
                    2: begin
                        plan[k] = $urandom_range(0, 1) ? WREG_W'($urandom) : '0;
                    end
                    3: begin
                        plan[k] = '0;
                    end
                    4: begin
                        plan[k] = '0;
                    end
                    5: begin
                        plan[k] = '1;
                    end
                    default: begin
                        plan[k] = $urandom_range(0, 1) ? '1 : WREG_W'(1);
                    end
                endcase
            end
            if (shape == 4)
                plan[$urandom_range(0, NUM_SLOTS - 1)] =
                    $urandom_range(0, 1) ? '1 : WREG_W'($urandom);
            write_weights(plan);

            total_w = 0;
            for (int k = 0; k < NUM_SLOTS; k++)
                total_w += plan[k];
            for (int n = 0; n < DRAWS_PER_SETTING; n++) begin
                if (total_w == 0 || $urandom_range(0, 1)) begin
                    queue_draw(FRAC_W'($urandom));
                end else begin
                    // land on or next to a running-sum boundary
                    pick = $urandom_range(0, NUM_SLOTS - 2);
                    cum_w = 0;
                    for (int k = 0; k <= pick; k++)
                        cum_w += plan[k];
                    frac = (cum_w * 65536 + total_w - 1) / total_w;
                    frac = frac + $urandom_range(0, 2) - 1;
                    if (frac < 0)
                        frac = 0;
                    if (frac > 65535)
                        frac = 65535;
                    queue_draw(FRAC_W'(frac));
                end
            end
            wait_drain();
        end

        repeat (10) @(posedge aclk);
        if (expected_draws.size() != 0)
            report_mismatch($sformatf("%0d draws never returned", expected_draws.size()));

        $display("covered %0d draws under %0d weight settings (%0d with zero total weight)",
            draws_checked, settings_applied + 1, zero_total_draws);
        $display("%0d draws accepted, %0d mismatches", draws_accepted, error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wmcs_pkg.sv
rtl/wmcs_regs.sv
rtl/wmcs_scale.sv
rtl/wmcs_pick.sv
rtl/weighted_mixture_component_select.sv
test/tb_weighted_mixture_component_select.sv
